/* src/ibca_pkg.sv */
// Shared types, constants and helpers for the interval bin coverage accumulator.
package ibca_pkg;

    localparam int CHROMOSOMES_DEF = 23;
    localparam int BINS_PER_CHROMOSOME_DEF = 256;

    localparam int CHR_W = 5;
    localparam int POS_W = 28;
    localparam int SCORE_W = 32;
    localparam int BIN_SIZE_W = 24;
    localparam int COV_W = 24;
    localparam int STATUS_W = 2;
    localparam int FRAC_SHIFT = 16;
    localparam int FRAC_W = FRAC_SHIFT + 1;
    localparam int DVD_W = BIN_SIZE_W + FRAC_SHIFT;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;

    localparam logic [BIN_SIZE_W-1:0] BIN_SIZE_RST = 24'd1000000;
    localparam logic [COV_W-1:0] COV_ONE = 24'h010000;
    localparam logic [COV_W-1:0] COV_MAX = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_SKIP  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic                  go;
        logic [DVD_W-1:0]      dividend;
        logic [BIN_SIZE_W-1:0] divisor;
    } div_req_t;

    function automatic logic [COV_W-1:0] sat_add(input logic [COV_W-1:0] a,
                                                 input logic [FRAC_W-1:0] f);
        logic [COV_W:0] sum;
        begin
            sum = {1'b0, a} + (COV_W+1)'(f);
            sat_add = sum[COV_W] ? COV_MAX : sum[COV_W-1:0];
        end
    endfunction

endpackage

/* src/interval_bin_coverage_accumulator.sv */
// Top level: coverage table in block memory with divide, read-modify-write and fill sequencer.
//
// Input items arrive on s_tvalid/s_tready/s_tdata with the request type on s_tuser.
// An add item divides start and end by bin_size in two parallel bit-serial
// dividers, range-checks the bins, then divides the edge fractions,
// read-modify-writes the start and end bins with saturation and
// writes 1.0 into each bin in between, one bin per cycle on the memory write port.
// An add whose start and end bins differ also read-modify-writes the end bin and
// then fills the middle bins; a read item only reads its bin from memory; an item
// rejected at decode, or whose bins fall out of range, goes straight to the result.
// One item is worked on at a time; each yields one result on m_tvalid/m_tready/m_tdata.
// The result sits in an output register; s_tready returns high once it is loaded,
// so a stalled receiver holds only the next result back, not the next accept.
// Configuration writes on cfg_valid/cfg_ready are taken every cycle.
// After reset the table is cleared one entry per cycle, all CHROMOSOMES *
// BINS_PER_CHROMOSOME entries (5888 by default); s_tready stays low during this.
module interval_bin_coverage_accumulator #(
    parameter int CHROMOSOMES = ibca_pkg::CHROMOSOMES_DEF,
    parameter int BINS_PER_CHROMOSOME = ibca_pkg::BINS_PER_CHROMOSOME_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // chromosome[4:0], start_pos[32:5], end_pos[60:33], score[92:61], zeros
    input  logic [ibca_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], coverage[25:2], zeros
    output logic [ibca_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ibca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH  = CHROMOSOMES * BINS_PER_CHROMOSOME;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = (BINS_PER_CHROMOSOME > 2) ? $clog2(BINS_PER_CHROMOSOME) : 1;
    localparam int CHR_W  = ibca_pkg::CHR_W;
    localparam int POS_W  = ibca_pkg::POS_W;
    localparam int COV_W  = ibca_pkg::COV_W;
    localparam int BSW    = ibca_pkg::BIN_SIZE_W;
    localparam int DW     = ibca_pkg::DVD_W;
    localparam int FW     = ibca_pkg::FRAC_W;
    localparam int FS     = ibca_pkg::FRAC_SHIFT;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DIV_POS,
        S_CHECK,
        S_DIV_FRAC,
        S_RMW_S_RD,
        S_RMW_S_WR,
        S_RMW_E_RD,
        S_RMW_E_WR,
        S_FILL,
        S_RESP
    } state_t;

    state_t                     state_reg;
    logic [ADDR_W-1:0]          clr_reg;
    logic                       div_go_reg;
    logic                       m_valid_reg;
    logic [ibca_pkg::STATUS_W-1:0] m_status_reg;
    logic [COV_W-1:0]           m_cov_reg;

    logic [BSW-1:0]             bin_size_reg;
    logic signed [ibca_pkg::SCORE_W-1:0] thr_reg;

    logic                       req_reg;
    logic [CHR_W-1:0]           chr_reg;
    logic [POS_W-1:0]           start_reg;
    logic [POS_W-1:0]           end_reg;
    logic signed [ibca_pkg::SCORE_W-1:0] score_reg;
    logic [ADDR_W-1:0]          base_reg;
    logic [BIN_W-1:0]           sb_reg;
    logic [BIN_W-1:0]           eb_reg;
    logic [BIN_W-1:0]           fill_reg;
    logic                       same_reg;
    logic [DW-1:0]              dvd_a_reg;
    logic [DW-1:0]              dvd_b_reg;
    logic [ibca_pkg::STATUS_W-1:0] status_reg;
    logic [COV_W-1:0]           cov_reg;

    logic [COV_W-1:0]           mem [DEPTH];
    logic [COV_W-1:0]           rdata_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [COV_W-1:0]           mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;

    ibca_pkg::div_req_t         req_a;
    ibca_pkg::div_req_t         req_b;
    logic                       done_a;
    logic                       done_b;
    logic [DW-1:0]              quo_a;
    logic [DW-1:0]              quo_b;
    logic [BSW-1:0]             rem_a;
    logic [BSW-1:0]             rem_b;

    logic                       chr_bad;
    logic                       start_bad;
    logic                       sb_bad;
    logic                       eb_bad;
    logic                       slot_free;
    logic [BIN_W:0]             sb_inc;
    logic [BIN_W:0]             fill_inc;

    assign req_a = '{go: div_go_reg, dividend: dvd_a_reg, divisor: bin_size_reg};
    assign req_b = '{go: div_go_reg, dividend: dvd_b_reg, divisor: bin_size_reg};

    ibca_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_a),
        .done      (done_a),
        .quotient  (quo_a),
        .remainder (rem_a)
    );

    ibca_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_b),
        .done      (done_b),
        .quotient  (quo_b),
        .remainder (rem_b)
    );

    assign chr_bad   = (chr_reg == '0) || (chr_reg > CHR_W'(CHROMOSOMES));
    assign start_bad = start_reg >= POS_W'(BINS_PER_CHROMOSOME);
    assign sb_bad    = quo_a[POS_W-1:0] >= POS_W'(BINS_PER_CHROMOSOME);
    assign eb_bad    = quo_b[POS_W-1:0] >= POS_W'(BINS_PER_CHROMOSOME);
    assign slot_free = !m_valid_reg || m_tready;
    assign sb_inc    = {1'b0, sb_reg} + 1'b1;
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(ibca_pkg::M_TDATA_W - COV_W - ibca_pkg::STATUS_W){1'b0}},
                        m_cov_reg, m_status_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = base_reg + ADDR_W'(sb_reg);
        mem_wdata = ibca_pkg::sat_add(rdata_reg, quo_a[FW-1:0]);
        mem_raddr = base_reg + ADDR_W'(sb_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_RD_ISSUE:
            begin
                mem_raddr = base_reg + ADDR_W'(start_reg[BIN_W-1:0]);
            end
            S_RMW_S_WR:
            begin
                mem_we = 1'b1;
            end
            S_RMW_E_RD:
            begin
                mem_raddr = base_reg + ADDR_W'(eb_reg);
            end
            S_RMW_E_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(eb_reg);
                mem_wdata = ibca_pkg::sat_add(rdata_reg, quo_b[FW-1:0]);
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(fill_reg);
                mem_wdata = ibca_pkg::COV_ONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_size_reg <= ibca_pkg::BIN_SIZE_RST;
            thr_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ibca_pkg::CFG_BIN_SIZE:  bin_size_reg <= cfg_data[BSW-1:0];
                ibca_pkg::CFG_THRESHOLD: thr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            div_go_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= '0;
            m_cov_reg    <= '0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (m_valid_reg && m_tready && (state_reg != S_RESP))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (req_reg == ibca_pkg::REQ_READ)
                    begin
                        state_reg <= (chr_bad || start_bad) ? S_RESP : S_RD_ISSUE;
                    end
                    else if (chr_reg == '0 || score_reg <= thr_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (chr_bad || bin_size_reg == '0 || end_reg < start_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= S_DIV_POS;
                    end
                end
                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA:
                begin
                    state_reg <= S_RESP;
                end
                S_DIV_POS:
                begin
                    if (done_a && done_b)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (sb_bad || eb_bad)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= S_DIV_FRAC;
                    end
                end
                S_DIV_FRAC:
                begin
                    if (done_a && done_b)
                    begin
                        state_reg <= S_RMW_S_RD;
                    end
                end
                S_RMW_S_RD:
                begin
                    state_reg <= S_RMW_S_WR;
                end
                S_RMW_S_WR:
                begin
                    state_reg <= same_reg ? S_RESP : S_RMW_E_RD;
                end
                S_RMW_E_RD:
                begin
                    state_reg <= S_RMW_E_WR;
                end
                S_RMW_E_WR:
                begin
                    state_reg <= (sb_inc == {1'b0, eb_reg}) ? S_RESP : S_FILL;
                end
                S_FILL:
                begin
                    if (fill_inc == {1'b0, eb_reg})
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (slot_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_cov_reg    <= cov_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg    <= s_tuser;
                chr_reg    <= s_tdata[4:0];
                start_reg  <= s_tdata[32:5];
                end_reg    <= s_tdata[60:33];
                score_reg  <= s_tdata[92:61];
                status_reg <= ibca_pkg::ST_DONE;
                cov_reg    <= '0;
            end
            S_DECODE:
            begin
                base_reg  <= ADDR_W'((32'(chr_reg) - 32'd1) * 32'(BINS_PER_CHROMOSOME));
                dvd_a_reg <= DW'(start_reg);
                dvd_b_reg <= DW'(end_reg);
                if (req_reg == ibca_pkg::REQ_READ)
                begin
                    if (chr_bad || start_bad)
                    begin
                        status_reg <= ibca_pkg::ST_RANGE;
                    end
                end
                else if (chr_reg == '0 || score_reg <= thr_reg)
                begin
                    status_reg <= ibca_pkg::ST_SKIP;
                end
                else if (chr_bad || bin_size_reg == '0 || end_reg < start_reg)
                begin
                    status_reg <= ibca_pkg::ST_RANGE;
                end
            end
            S_RD_DATA:
            begin
                cov_reg <= rdata_reg;
            end
            S_CHECK:
            begin
                sb_reg   <= quo_a[BIN_W-1:0];
                eb_reg   <= quo_b[BIN_W-1:0];
                same_reg <= quo_a[POS_W-1:0] == quo_b[POS_W-1:0];
                fill_reg <= quo_a[BIN_W-1:0] + 1'b1;
                if (sb_bad || eb_bad)
                begin
                    status_reg <= ibca_pkg::ST_RANGE;
                end
                if (quo_a[POS_W-1:0] == quo_b[POS_W-1:0])
                begin
                    dvd_a_reg <= {rem_b - rem_a, {FS{1'b0}}};
                end
                else
                begin
                    dvd_a_reg <= {bin_size_reg - rem_a, {FS{1'b0}}};
                end
                dvd_b_reg <= {rem_b, {FS{1'b0}}};
            end
            S_FILL:
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/ibca_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module ibca_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ibca_pkg::div_req_t                req,
    output logic                              done,
    output logic [ibca_pkg::DVD_W-1:0]        quotient,
    output logic [ibca_pkg::BIN_SIZE_W-1:0]   remainder
);

    localparam int DW = ibca_pkg::DVD_W;
    localparam int BW = ibca_pkg::BIN_SIZE_W;
    localparam int CW = ibca_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] dvs_reg;

    logic [BW:0]   shifted;
    logic [BW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[BW-1:0] : shifted[BW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule
